[hdl/rope_pkg.sv]
// rope_pkg: shared constants, beat types, frequency and arctangent tables
// for the rotary position embedding unit; no dependencies
package rope_pkg;

    localparam int HEAD_SIZE     = 64;
    localparam int D_W           = $clog2(HEAD_SIZE);
    localparam int POS_W         = 11;
    localparam int CORDIC_STEPS  = 30;
    localparam int CW            = 34;

    localparam logic [63:0] LOG2_TENK_Q24  = 64'd222930821;
    localparam logic [63:0] LN2_Q32        = 64'd2977044472;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30         = 34'sd1073741824;

    typedef struct packed {
        logic [8:0]         element_index;
        logic signed [31:0] query_even;
        logic signed [31:0] query_odd;
        logic signed [31:0] key_even;
        logic signed [31:0] key_odd;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] rot_query_even;
        logic signed [31:0] rot_query_odd;
        logic signed [31:0] rot_key_even;
        logic signed [31:0] rot_key_odd;
    } out_beat_t;

    // pipeline advance and valid travel together into the cordic
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    typedef logic [31:0] freq_tab_t [HEAD_SIZE];
    typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

    localparam atan_tab_t ATAN_TURNS = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // frequency in Q32 turns per position, evaluated at elaboration only
    function automatic logic [31:0] freq_calc(int unsigned d);
        logic [63:0] x;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] res;
        x   = (64'(d) * LOG2_TENK_Q24) / HEAD_SIZE;
        n   = x >> 24;
        r   = x & 64'hFF_FFFF;
        y   = (r * LN2_Q32) >> 24;
        sum = 64'd1 << 32;
        t   = 64'd1 << 32;
        for (int k = 1; k <= 20; k++) begin
            t = ((t * y) >> 32) / 64'(k);
            if (k % 2 == 1) begin
                sum = sum - t;
            end else begin
                sum = sum + t;
            end
        end
        if (n > 64'd63) begin
            n = 64'd63;
        end
        sum = sum >> n;
        res = (sum * INV_TWO_PI_Q32 + 64'h8000_0000) >> 32;
        return res[31:0];
    endfunction

    function automatic freq_tab_t build_freq_tab();
        freq_tab_t tab;
        for (int d = 0; d < HEAD_SIZE; d++) begin
            tab[d] = freq_calc(d);
        end
        return tab;
    endfunction

    localparam freq_tab_t FREQ_TAB = build_freq_tab();

endpackage

[hdl/rope_cordic.sv]
// rope_cordic: pipelined rotation-mode cordic, one step per stage
// depends on rope_pkg; carries the input beat alongside the angle
module rope_cordic import rope_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  pipe_ctl_t          ctl,
    input  logic [31:0]        phase,
    input  in_beat_t           pay_in,
    output logic               out_valid,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out,
    output in_beat_t           pay_out
);

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 neg_reg [CORDIC_STEPS+1];
    logic                 vld_reg [CORDIC_STEPS+1];
    in_beat_t             pay_reg [CORDIC_STEPS+1];

    logic                 out_valid_reg;
    logic signed [31:0]   cos_reg;
    logic signed [31:0]   sin_reg;
    in_beat_t             pay_out_reg;

    logic                 fold_neg;
    logic [31:0]          fold_phase;
    logic signed [CW-1:0] cx_clamp;
    logic signed [CW-1:0] cy_clamp;
    logic signed [CW-1:0] cx_next;
    logic signed [CW-1:0] cy_next;

    // second and third quarter move by half a turn
    assign fold_neg   = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
    assign fold_phase = fold_neg ? {~phase[31], phase[30:0]} : phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ctl.en) begin
            vld_reg[0] <= ctl.valid;
        end
        if (ctl.en) begin
            x_reg[0]   <= CORDIC_GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= CW'(signed'(fold_phase));
            neg_reg[0] <= fold_neg;
            pay_reg[0] <= pay_in;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] ang;
        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign ang = CW'(ATAN_TURNS[i]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (ctl.en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (ctl.en) begin
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ang;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                neg_reg[i+1] <= neg_reg[i];
                pay_reg[i+1] <= pay_reg[i];
            end
        end
    end

    // clamp to unit range, undo the half-turn fold
    always_comb begin
        cx_clamp = x_reg[CORDIC_STEPS];
        cy_clamp = y_reg[CORDIC_STEPS];
        if (cx_clamp > ONE_Q30) cx_clamp = ONE_Q30;
        if (cx_clamp < -ONE_Q30) cx_clamp = -ONE_Q30;
        if (cy_clamp > ONE_Q30) cy_clamp = ONE_Q30;
        if (cy_clamp < -ONE_Q30) cy_clamp = -ONE_Q30;
        cx_next = neg_reg[CORDIC_STEPS] ? -cx_clamp : cx_clamp;
        cy_next = neg_reg[CORDIC_STEPS] ? -cy_clamp : cy_clamp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.en) begin
            out_valid_reg <= vld_reg[CORDIC_STEPS];
        end
        if (ctl.en) begin
            cos_reg     <= cx_next[31:0];
            sin_reg     <= cy_next[31:0];
            pay_out_reg <= pay_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;
    assign pay_out   = pay_out_reg;

endmodule

[hdl/rope_rot_lane.sv]
// rope_rot_lane: rotates one (even, odd) pair by cos/sin in Q30
// depends on rope_pkg; two stages: products, then round and saturate
module rope_rot_lane import rope_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] val_even,
    input  logic signed [31:0] val_odd,
    input  logic signed [31:0] cos_in,
    input  logic signed [31:0] sin_in,
    output logic signed [31:0] rot_even,
    output logic signed [31:0] rot_odd
);

    logic signed [63:0] p_ec_reg;
    logic signed [63:0] p_os_reg;
    logic signed [63:0] p_es_reg;
    logic signed [63:0] p_oc_reg;
    logic signed [31:0] rot_even_reg;
    logic signed [31:0] rot_odd_reg;

    logic signed [64:0] acc_even;
    logic signed [64:0] acc_odd;

    function automatic logic signed [31:0] finish(logic signed [64:0] acc);
        logic signed [64:0] v;
        v = (acc + 65'sd536870912) >>> 30;
        if (v > 65'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -65'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    assign acc_even = 65'(p_ec_reg) - 65'(p_os_reg);
    assign acc_odd  = 65'(p_es_reg) + 65'(p_oc_reg);

    // products, then exact sum, round and saturate
    always_ff @(posedge aclk) begin
        if (en) begin
            p_ec_reg     <= 64'(val_even) * 64'(cos_in);
            p_os_reg     <= 64'(val_odd) * 64'(sin_in);
            p_es_reg     <= 64'(val_even) * 64'(sin_in);
            p_oc_reg     <= 64'(val_odd) * 64'(cos_in);
            rot_even_reg <= finish(acc_even);
            rot_odd_reg  <= finish(acc_odd);
        end
    end

    assign rot_even = rot_even_reg;
    assign rot_odd  = rot_odd_reg;

endmodule

[hdl/rotary_position_embedding_unit.sv]
// rotary_position_embedding_unit: top level, angle pipeline, two rotation
// lanes and output stage; depends on rope_pkg, rope_cordic, rope_rot_lane

// One beat per cycle while the output is not held: a pair of query values and
// a pair of key values with their element index go in, and the rotated pairs
// come out in order. The whole pipeline moves as one: it advances whenever the
// output register is empty or being taken, so s_ready follows m_ready while a
// result is held. The depth is set by the 30-stage cordic; frequency lookup and
// the position multiply take two stages ahead of it, the rotation lanes two
// after it, then the output register. The token position (pos_reg) is written
// with cfg_we and must only change while no beats are in flight.
module rotary_position_embedding_unit import rope_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [POS_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data
);

    logic [POS_W-1:0] pos_reg;
    logic             en;

    logic             v1_reg;
    logic [31:0]      freq_reg;
    in_beat_t         pay1_reg;
    logic             v2_reg;
    logic [31:0]      phase_reg;
    in_beat_t         pay2_reg;

    pipe_ctl_t          cordic_ctl;
    logic               cordic_valid;
    logic signed [31:0] cos_w;
    logic signed [31:0] sin_w;
    in_beat_t           cordic_pay;

    logic       l1_reg;
    logic       l2_reg;
    out_beat_t  lane_beat;
    logic       m_valid_reg;
    out_beat_t  m_data_reg;
    logic [POS_W+31:0] phase_full;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // position register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cfg_we) begin
            pos_reg <= cfg_wdata;
        end
    end

    // frequency lookup, then angle as position times frequency, mod one turn
    assign phase_full = (POS_W+32)'(pos_reg) * (POS_W+32)'(freq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            freq_reg  <= FREQ_TAB[s_data.element_index[D_W-1:0]];
            pay1_reg  <= s_data;
            phase_reg <= phase_full[31:0];
            pay2_reg  <= pay1_reg;
        end
    end

    assign cordic_ctl.en    = en;
    assign cordic_ctl.valid = v2_reg;

    rope_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (cordic_ctl),
        .phase     (phase_reg),
        .pay_in    (pay2_reg),
        .out_valid (cordic_valid),
        .cos_out   (cos_w),
        .sin_out   (sin_w),
        .pay_out   (cordic_pay)
    );

    // query and key lanes share the angle
    rope_rot_lane u_lane_q (
        .aclk     (aclk),
        .en       (en),
        .val_even (cordic_pay.query_even),
        .val_odd  (cordic_pay.query_odd),
        .cos_in   (cos_w),
        .sin_in   (sin_w),
        .rot_even (lane_beat.rot_query_even),
        .rot_odd  (lane_beat.rot_query_odd)
    );

    rope_rot_lane u_lane_k (
        .aclk     (aclk),
        .en       (en),
        .val_even (cordic_pay.key_even),
        .val_odd  (cordic_pay.key_odd),
        .cos_in   (cos_w),
        .sin_in   (sin_w),
        .rot_even (lane_beat.rot_key_even),
        .rot_odd  (lane_beat.rot_key_odd)
    );

    // lane valid tracking and merged output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg      <= 1'b0;
            l2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            l1_reg      <= cordic_valid;
            l2_reg      <= l1_reg;
            m_valid_reg <= l2_reg;
        end
        if (en) begin
            m_data_reg <= lane_beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("output valid after reset");

    a_ready_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready)) else $error("ready not tied to output");

    a_hold_result : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("held result changed");

    a_pipe_advance : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg) else $error("accepted beat lost");

endmodule
